@@ src/servo_drive_enable_sequencer_assert.svh @@
// Assertion macros for the servo drive enable sequencer
`ifndef SERVO_DRIVE_ENABLE_SEQUENCER_ASSERT_SVH
`define SERVO_DRIVE_ENABLE_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SDES_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SDES_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ src/sdes_pkg.sv @@
// Shared types, constants and helpers of the servo drive enable sequencer
package sdes_pkg;

   localparam int MOTOR_COUNT = 8;
   localparam int MOTOR_W     = 3;

   // control words
   localparam logic [15:0] CW_SHUTDOWN      = 16'd6;
   localparam logic [15:0] CW_SWITCH_ON     = 16'd7;
   localparam logic [15:0] CW_ENABLE_OP     = 16'd15;
   localparam logic [15:0] RUN_TORQUE_LIMIT = 16'd5000;

   // status word bits
   localparam int SW_READY   = 0;
   localparam int SW_ON      = 1;
   localparam int SW_OP_EN   = 2;
   localparam int SW_FAULT   = 3;

   // phases
   localparam logic [2:0] PHASE_INITIAL  = 3'd0;
   localparam logic [2:0] PHASE_ENABLING = 3'd1;
   localparam logic [2:0] PHASE_RUNNING  = 3'd2;
   localparam logic [2:0] PHASE_FAULT    = 3'd3;
   localparam logic [2:0] PHASE_SWITCH   = 3'd4;

   // mode-switch sub-steps
   localparam logic [2:0] SUB_IDLE      = 3'd0;
   localparam logic [2:0] SUB_SET_MODE  = 3'd1;
   localparam logic [2:0] SUB_SWITCH_ON = 3'd2;
   localparam logic [2:0] SUB_ENABLE    = 3'd3;
   localparam logic [2:0] SUB_DONE      = 3'd4;

   // drive operating modes
   localparam logic signed [7:0] MODE_POSITION = 8'sd8;
   localparam logic signed [7:0] MODE_VELOCITY = 8'sd9;
   localparam logic signed [7:0] MODE_TORQUE   = 8'sd10;

   // target mode selector codes
   localparam logic [1:0] TM_VELOCITY = 2'd1;
   localparam logic [1:0] TM_TORQUE   = 2'd2;

   // reciprocal division: q = (op * RECIP) >> 32, then one correction step
   localparam int OP_W    = 31;
   localparam int RECIP_W = 29;
   localparam int PROD_W  = OP_W + RECIP_W;
   localparam int QUOT_W  = PROD_W - 32;
   localparam int REM_W   = 34;
   localparam logic [RECIP_W-1:0] VEL_RECIP = 29'd286331153;  // floor(2^32 / 15)
   localparam logic [RECIP_W-1:0] POS_RECIP = 29'd95443717;   // floor(2^32 / 45)
   localparam int VEL_DIV = 15;
   localparam int POS_DIV = 45;

   typedef struct packed {
      logic [2:0]  phase;
      logic [2:0]  substep;
      logic [15:0] control;
      logic [7:0]  mode;
      logic [31:0] position;
      logic [31:0] velocity;
      logic [15:0] torque;
      logic [15:0] limit;
   } entry_type;

   typedef struct packed {
      logic [MOTOR_W-1:0] motor_index;
      logic [15:0]        drive_status;
      logic signed [7:0]  drive_mode;
      logic [31:0]        actual_position;
   } req_type;

   typedef struct packed {
      logic [31:0] velocity;
      logic [31:0] position;
      logic [15:0] torque;
   } scaled_type;

   function automatic logic signed [7:0] want_mode(input logic [15:0] modes,
                                                   input logic [MOTOR_W-1:0] idx);
      logic [1:0] sel;
      sel = 2'(modes >> {idx, 1'b0});
      case (sel)
         TM_VELOCITY: want_mode = MODE_VELOCITY;
         TM_TORQUE:   want_mode = MODE_TORQUE;
         default:     want_mode = MODE_POSITION;
      endcase
   endfunction

endpackage

@@ src/sdes_entry_ram.sv @@
// Per-motor state memory with registered read and reset-cleared valid bits
module sdes_entry_ram import sdes_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [MOTOR_W-1:0] rd_addr,
   output entry_type          rd_entry,
   input  logic               wr_en,
   input  logic [MOTOR_W-1:0] wr_addr,
   input  entry_type          wr_entry
);

   entry_type              mem_ff [MOTOR_COUNT];
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;
   logic [MOTOR_COUNT-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // an entry never written since reset reads as all zero
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ src/sdes_scaler.sv @@
// Setpoint scaling pipeline: magnitude, reciprocal multiply, correction, sign
module sdes_scaler import sdes_pkg::*; (
   input  logic               clock,
   input  logic               load,
   input  logic signed [31:0] setpoint,
   input  logic               vel_sel,
   output scaled_type         scaled
);

   logic [31:0]        sp_bits;
   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               vel_sel_ff, vel_sel_in;
   logic [47:0]        times_full;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [15:0]        tor_ff, tor_in;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [QUOT_W-1:0]  q0, q;
   logic [REM_W-1:0]   q0x, prod_d, rem, divisor;
   logic [31:0]        qx;
   scaled_type         res_ff, res_in;

   always_comb begin
      sp_bits    = setpoint;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      vel_sel_in = vel_sel_ff;
      if (load) begin
         neg_in     = sp_bits[31];
         mag_in     = sp_bits[31] ? (~sp_bits + 32'd1) : sp_bits;
         vel_sel_in = vel_sel;
      end

      // position: floor(|S| * 65535 / 2^18), then divide by 45
      times_full = {mag_ff, 16'd0} - {16'd0, mag_ff};
      op_in      = vel_sel_ff ? mag_ff[31:1] : {2'd0, times_full[46:18]};
      tor_in     = neg_ff ? (~mag_ff[31:16] + 16'd1) : mag_ff[31:16];

      recip   = vel_sel_ff ? VEL_RECIP : POS_RECIP;
      prod_in = PROD_W'(op_ff) * PROD_W'(recip);

      // estimate is exact or one short: fix with a single compare
      q0      = prod_ff[PROD_W-1:32];
      q0x     = REM_W'(q0);
      prod_d  = vel_sel_ff ? ((q0x << 4) - q0x)
                           : ((q0x << 5) + (q0x << 3) + (q0x << 2) + q0x);
      divisor = vel_sel_ff ? REM_W'(VEL_DIV) : REM_W'(POS_DIV);
      rem     = REM_W'(op_ff) - prod_d;
      q       = (rem >= divisor) ? (q0 + QUOT_W'(1)) : q0;
      qx      = 32'(q);

      res_in.velocity = neg_ff ? (~qx + 32'd1) : qx;
      res_in.position = neg_ff ? (~qx + 32'd1) : qx;
      res_in.torque   = tor_ff;
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      vel_sel_ff <= vel_sel_in;
      op_ff      <= op_in;
      tor_ff     <= tor_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
   end

   assign scaled = res_ff;

endmodule

@@ src/sdes_update.sv @@
// Next-entry logic: mode-change sequence, fault shutdown, enable walk, run
module sdes_update import sdes_pkg::*; (
   input  entry_type         cur,
   input  req_type           req,
   input  logic signed [7:0] want,
   input  scaled_type        scaled,
   output entry_type         nxt
);

   logic rdy, son, ope, fault;

   always_comb begin
      rdy   = req.drive_status[SW_READY];
      son   = req.drive_status[SW_ON];
      ope   = req.drive_status[SW_OP_EN];
      fault = req.drive_status[SW_FAULT];
      nxt   = cur;

      if ((req.drive_mode != want) || (cur.phase == PHASE_SWITCH)) begin
         nxt.phase = PHASE_SWITCH;
         case (cur.substep)
            SUB_SET_MODE: begin
               nxt.mode     = want;
               nxt.position = req.actual_position;
               nxt.velocity = '0;
               nxt.torque   = '0;
               nxt.control  = CW_SHUTDOWN;
               nxt.substep  = SUB_SWITCH_ON;
            end
            SUB_SWITCH_ON: begin
               if (!son && !ope && rdy) begin
                  nxt.control = CW_SWITCH_ON;
                  nxt.substep = SUB_ENABLE;
               end else begin
                  nxt.control = CW_SHUTDOWN;
               end
            end
            SUB_ENABLE: begin
               if (son) begin
                  if (ope) begin
                     nxt.substep = SUB_DONE;
                  end else begin
                     nxt.control = CW_ENABLE_OP;
                  end
               end else begin
                  nxt.control = CW_SWITCH_ON;
               end
            end
            SUB_DONE: begin
               if (req.drive_mode == want) begin
                  nxt.substep = SUB_IDLE;
                  nxt.phase   = PHASE_RUNNING;
               end
            end
            default: begin
               nxt.substep = SUB_SET_MODE;
            end
         endcase
      end else if (fault) begin
         nxt.phase   = PHASE_FAULT;
         nxt.control = CW_SHUTDOWN;
      end else begin
         if (!son && !rdy) begin
            nxt.control = CW_SHUTDOWN;
         end else if (!son) begin
            nxt.control = CW_SWITCH_ON;
         end else begin
            nxt.control = CW_ENABLE_OP;
         end
         if (ope) begin
            nxt.phase = PHASE_RUNNING;
            nxt.limit = RUN_TORQUE_LIMIT;
            if (want == MODE_VELOCITY) begin
               nxt.velocity = scaled.velocity;
            end else if (want == MODE_POSITION) begin
               nxt.position = scaled.position;
            end else begin
               nxt.torque = scaled.torque;
            end
         end else begin
            nxt.phase    = PHASE_ENABLING;
            nxt.position = req.actual_position;
            nxt.velocity = '0;
            nxt.torque   = '0;
         end
      end
   end

endmodule

@@ src/servo_drive_enable_sequencer.sv @@
// Top level of the servo drive enable sequencer
//
// Master side of a CiA 402 drive state machine for up to eight motors.
// Input item: a motor's status word, reported mode, actual position and a
// Q16.16 setpoint, taken at a rising edge where start is high and busy low.
// Configuration: the target modes register is written through
// csr_write_enable and csr_write_data, two bits per motor; write it only
// while busy is low.
// Each item yields one transmit record on the rsp_ ports, marked by
// rsp_strobe for exactly one cycle; the receiver cannot stall, so the record
// must be taken in that cycle.
// States after the accepting edge: PREP, MUL, FIX, WRITE; rsp_strobe is
// registered from WRITE, and no new item is taken until idle again. The
// per-motor entry is read at the accepting edge and written back in WRITE;
// busy stays high across that read-modify-write and the four-stage scaling
// pipeline (magnitude, reciprocal multiply, correction, apply).
// Reset: synchronous, active high; all motor entries read as zero until
// first written, the target modes register clears and busy drops.
`include "servo_drive_enable_sequencer_assert.svh"

module servo_drive_enable_sequencer import sdes_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MOTOR_W-1:0]  req_motor_index,
   input  logic [15:0]         req_drive_status,
   input  logic signed [7:0]   req_drive_mode_in,
   input  logic signed [31:0]  req_actual_position,
   input  logic signed [31:0]  req_setpoint,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   output logic                rsp_strobe,
   output logic [MOTOR_W-1:0]  rsp_motor_id,
   output logic [15:0]         rsp_command,
   output logic signed [7:0]   rsp_mode_request,
   output logic signed [31:0]  rsp_target_position,
   output logic signed [31:0]  rsp_target_velocity,
   output logic signed [15:0]  rsp_torque_demand,
   output logic [15:0]         rsp_torque_limit,
   output logic [2:0]          rsp_phase
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PREP  = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_FIX   = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [15:0]        modes_ff, modes_in;
   req_type            req_ff, req_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [MOTOR_W-1:0] rsp_id_ff, rsp_id_in;
   entry_type          rsp_entry_ff, rsp_entry_in;

   logic               accept;
   logic               write_back;
   logic signed [7:0]  want_acc, want_held;
   entry_type          cur_entry, nxt_entry;
   scaled_type         scaled;

   assign accept     = start && (state_ff == ST_IDLE);
   assign write_back = (state_ff == ST_WRITE);
   assign want_acc   = want_mode(modes_ff, req_motor_index);
   assign want_held  = want_mode(modes_ff, req_ff.motor_index);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_PREP;
         ST_PREP:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_FIX;
         ST_FIX:   state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      modes_in = csr_write_enable ? csr_write_data : modes_ff;

      req_in = req_ff;
      if (accept) begin
         req_in.motor_index     = req_motor_index;
         req_in.drive_status    = req_drive_status;
         req_in.drive_mode      = req_drive_mode_in;
         req_in.actual_position = req_actual_position;
      end

      rsp_strobe_in = write_back;
      rsp_id_in     = write_back ? req_ff.motor_index : rsp_id_ff;
      rsp_entry_in  = write_back ? nxt_entry : rsp_entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         modes_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         modes_ff      <= modes_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_entry_ff <= rsp_entry_in;
   end

   sdes_entry_ram u_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_motor_index),
      .rd_entry (cur_entry),
      .wr_en    (write_back),
      .wr_addr  (req_ff.motor_index),
      .wr_entry (nxt_entry)
   );

   sdes_scaler u_scaler (
      .clock    (clock),
      .load     (accept),
      .setpoint (req_setpoint),
      .vel_sel  (want_acc == MODE_VELOCITY),
      .scaled   (scaled)
   );

   sdes_update u_update (
      .cur    (cur_entry),
      .req    (req_ff),
      .want   (want_held),
      .scaled (scaled),
      .nxt    (nxt_entry)
   );

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_motor_id        = rsp_id_ff;
   assign rsp_command         = rsp_entry_ff.control;
   assign rsp_mode_request    = $signed(rsp_entry_ff.mode);
   assign rsp_target_position = $signed(rsp_entry_ff.position);
   assign rsp_target_velocity = $signed(rsp_entry_ff.velocity);
   assign rsp_torque_demand   = $signed(rsp_entry_ff.torque);
   assign rsp_torque_limit    = rsp_entry_ff.limit;
   assign rsp_phase           = rsp_entry_ff.phase;

   `SDES_ASSERT_NEXT(a_accept_starts, clock, reset, start && !busy, state_ff == ST_PREP, "lost")
   `SDES_ASSERT_NEXT(a_write_strobes, clock, reset, write_back, rsp_strobe && !busy, "no result")
   `SDES_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, state_ff == ST_IDLE, "result in flight")
   `SDES_ASSERT_NOW(a_phase_legal, clock, reset, rsp_strobe, rsp_phase <= PHASE_SWITCH, "bad phase")

endmodule
